// ----- sv/trailing_annotation_bracket_scanner_macros.svh -----
// assertion macros for the trailing annotation bracket scanner checker
// no dependencies; pulled in by the checker file
`ifndef TRAILING_ANNOTATION_BRACKET_SCANNER_MACROS_SVH
`define TRAILING_ANNOTATION_BRACKET_SCANNER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TABS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// next-cycle implication, disabled while reset is low
`define TABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// ----- sv/tabs_pkg.sv -----
// shared types and constants for the trailing annotation bracket scanner
// no dependencies
package tabs_pkg;

    localparam int unsigned MAX_BRACE_DEPTH = 255;

    // scan mode codes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_SKIP  = 2'd1;
    localparam logic [1:0] MODE_WATCH = 2'd2;
    localparam logic [1:0] MODE_SLASH = 2'd3;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [1:0] mode;
        logic       later_bracket;
        logic       last_close;
        logic       prev_blank;
    } t_flags;

endpackage

// ----- sv/trailing_annotation_bracket_scanner.sv -----
// top level of the trailing annotation bracket scanner
// depends on tabs_pkg, tabs_step and tabs_out_reg
//
//   channel   handshake            payload
//   input     i_valid / o_ready    i_start_req, i_allowed, i_ch, i_at_eof
//   output    o_valid / i_ready    o_is_annotation
//
// one character per cycle while the output takes its results; a character is captured in
// the input register, and its result is then registered with the scan state in the result register
// the scan state updates in one step of tabs_step per character
// reset clears the scan mode, brace depth and both valid flags
// a stalled output holds the character in the input register, which then
// backpressures the input channel
module trailing_annotation_bracket_scanner #(
    parameter int unsigned MAX_BRACE_DEPTH = tabs_pkg::MAX_BRACE_DEPTH,
    localparam int unsigned BW = $clog2(MAX_BRACE_DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_start_req,
    input  logic       i_allowed,
    input  logic [7:0] i_ch,
    input  logic       i_at_eof,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_annotation
);

    logic             r_in_valid;
    logic             r_start_req;
    logic             r_allowed;
    logic [7:0]       r_ch;
    logic             r_at_eof;
    tabs_pkg::t_flags r_flags;
    tabs_pkg::t_flags n_flags;
    logic [BW-1:0]    r_brace;
    logic [BW-1:0]    n_brace;
    logic             res_valid;
    logic             res_value;
    logic             out_can_take;
    logic             advance;

    assign advance = r_in_valid && out_can_take;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_start_req <= i_start_req;
            r_allowed   <= i_allowed;
            r_ch        <= i_ch;
            r_at_eof    <= i_at_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '{mode: tabs_pkg::MODE_IDLE, later_bracket: 1'b0,
                         last_close: 1'b0, prev_blank: 1'b0};
            r_brace <= '0;
        end else if (advance) begin
            r_flags <= n_flags;
            r_brace <= n_brace;
        end
    end

    tabs_step #(
        .MAX_DEPTH (MAX_BRACE_DEPTH)
    ) u_step (
        .i_flags     (r_flags),
        .i_brace     (r_brace),
        .i_start_req (r_start_req),
        .i_allowed   (r_allowed),
        .i_ch        (r_ch),
        .i_at_eof    (r_at_eof),
        .o_flags     (n_flags),
        .o_brace     (n_brace),
        .o_res_valid (res_valid),
        .o_res_value (res_value)
    );

    tabs_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && res_valid),
        .i_value    (res_value),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_value    (o_is_annotation),
        .o_can_take (out_can_take)
    );

endmodule

// ----- sv/tabs_step.sv -----
// next-state and result logic for one character of the scanner
// depends on tabs_pkg
module tabs_step #(
    parameter int unsigned MAX_DEPTH = tabs_pkg::MAX_BRACE_DEPTH,
    localparam int unsigned BW = $clog2(MAX_DEPTH + 1)
) (
    input  tabs_pkg::t_flags i_flags,
    input  logic [BW-1:0]    i_brace,
    input  logic             i_start_req,
    input  logic             i_allowed,
    input  logic [7:0]       i_ch,
    input  logic             i_at_eof,
    output tabs_pkg::t_flags o_flags,
    output logic [BW-1:0]    o_brace,
    output logic             o_res_valid,
    output logic             o_res_value
);

    localparam logic [BW-1:0] MaxLevel = BW'(MAX_DEPTH);

    always_comb begin
        logic       blank;
        logic       run;
        logic       watch_en;
        logic       wl;
        logic       wp;
        logic [1:0] mode_eff;

        blank       = (i_ch == tabs_pkg::CH_SPACE) || (i_ch == tabs_pkg::CH_TAB);
        o_flags     = i_flags;
        o_brace     = i_brace;
        o_res_valid = 1'b0;
        o_res_value = 1'b0;
        watch_en    = 1'b0;
        wl          = i_flags.last_close;
        wp          = i_flags.prev_blank;
        mode_eff    = i_flags.mode;
        run         = 1'b1;

        if (i_start_req) begin
            if (!i_allowed) begin
                o_res_valid  = 1'b1;
                o_flags.mode = tabs_pkg::MODE_IDLE;
                run          = 1'b0;
            end else begin
                mode_eff = tabs_pkg::MODE_SKIP;
            end
        end

        if (run) begin
            unique case (mode_eff)
                tabs_pkg::MODE_SKIP: begin
                    if (!i_at_eof && blank) begin
                        o_flags.mode = tabs_pkg::MODE_SKIP;
                    end else if (!i_at_eof && i_ch == tabs_pkg::CH_LBRACK) begin
                        o_flags.mode          = tabs_pkg::MODE_WATCH;
                        o_flags.later_bracket = 1'b0;
                        o_flags.last_close    = 1'b0;
                        o_flags.prev_blank    = 1'b0;
                        o_brace               = '0;
                    end else begin
                        o_res_valid  = 1'b1;
                        o_flags.mode = tabs_pkg::MODE_IDLE;
                    end
                end
                tabs_pkg::MODE_WATCH: begin
                    watch_en = 1'b1;
                end
                tabs_pkg::MODE_SLASH: begin
                    if (!i_at_eof && (i_ch == tabs_pkg::CH_SLASH ||
                                      i_ch == tabs_pkg::CH_STAR)) begin
                        o_res_valid  = 1'b1;
                        o_res_value  = !i_flags.later_bracket && i_flags.last_close;
                        o_flags.mode = tabs_pkg::MODE_IDLE;
                    end else begin
                        // lone slash after a blank: treat it as the last non-blank
                        wl           = 1'b0;
                        wp           = 1'b0;
                        o_flags.mode = tabs_pkg::MODE_WATCH;
                        watch_en     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (watch_en) begin
            o_flags.last_close = wl;
            o_flags.prev_blank = wp;
            if (i_at_eof || i_ch == tabs_pkg::CH_LF || i_ch == tabs_pkg::CH_CR) begin
                o_res_valid  = 1'b1;
                o_res_value  = !i_flags.later_bracket && wl;
                o_flags.mode = tabs_pkg::MODE_IDLE;
            end else if (i_ch == tabs_pkg::CH_SLASH && wp) begin
                o_flags.mode = tabs_pkg::MODE_SLASH;
            end else if (i_ch == tabs_pkg::CH_RBRACE && i_brace == '0) begin
                o_res_valid  = 1'b1;
                o_res_value  = !i_flags.later_bracket && wl;
                o_flags.mode = tabs_pkg::MODE_IDLE;
            end else begin
                if (i_ch == tabs_pkg::CH_RBRACE) begin
                    o_brace = i_brace - BW'(1);
                end else if (i_ch == tabs_pkg::CH_LBRACE) begin
                    if (i_brace < MaxLevel) begin
                        o_brace = i_brace + BW'(1);
                    end
                end else if (i_ch == tabs_pkg::CH_LBRACK) begin
                    o_flags.later_bracket = 1'b1;
                end
                if (!blank) begin
                    o_flags.last_close = (i_ch == tabs_pkg::CH_RBRACK);
                end
                o_flags.prev_blank = blank;
            end
        end
    end

endmodule

// ----- sv/tabs_out_reg.sv -----
// result register between the scan logic and the output channel
// depends on nothing but its ports
module tabs_out_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_value,
    input  logic i_ready,
    output logic o_valid,
    output logic o_value,
    output logic o_can_take
);

    logic r_valid;
    logic r_value;
    logic n_valid;

    assign o_can_take = !r_valid || i_ready;
    assign n_valid    = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// ----- sv/tabs_chk.sv -----
// port-level checker for the trailing annotation bracket scanner, with its bind
// depends on trailing_annotation_bracket_scanner_macros.svh
`include "trailing_annotation_bracket_scanner_macros.svh"

module tabs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_start_req,
    input logic       i_allowed,
    input logic [7:0] i_ch,
    input logic       i_at_eof,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_is_annotation
);

    logic refused;
    logic no_answer;

    assign refused   = i_valid && o_ready && i_start_req && !i_allowed;
    assign no_answer = o_valid && !o_is_annotation;

    // a pending result holds until its transaction completes
    `TABS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    `TABS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_is_annotation))

    // with nothing waiting at the output the pipeline always drains
    `TABS_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)

    // a refused start gives a no answer if the output keeps moving
    `TABS_ASSERT_NEXT(a_refused_start, i_clk, i_rst_n, refused ##1 i_ready, no_answer)

endmodule

bind trailing_annotation_bracket_scanner tabs_chk u_chk (.*);

// ----- tb/tabs_scanner_checker.sv -----
`timescale 1ns / 1ps
// checker for the trailing annotation bracket scanner: watches both channels,
// predicts each verdict from the accepted characters and compares it with the output
// depends on tabs_pkg
module tabs_scanner_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_start_req,
    input  logic       i_allowed,
    input  logic [7:0] i_ch,
    input  logic       i_at_eof,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_is_annotation,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars,
    output int         o_verdicts,
    output int         o_annotations
);

    localparam int unsigned DEPTH_W = $clog2(tabs_pkg::MAX_BRACE_DEPTH + 1);

    tabs_pkg::t_flags   scan;
    logic [DEPTH_W-1:0] depth;
    logic               verdict_q[$];

    task automatic close_window(output logic verdict);
        verdict   = !scan.later_bracket && scan.last_close;
        scan.mode = tabs_pkg::MODE_IDLE;
    endtask

    // one character seen while the window after the opener is open
    task automatic watch_char(input logic [7:0] c, input logic eof,
                              output logic hit, output logic verdict);
        logic is_blank;
        is_blank = (c == tabs_pkg::CH_SPACE) || (c == tabs_pkg::CH_TAB);
        hit      = 1'b0;
        verdict  = 1'b0;
        if (eof || c == tabs_pkg::CH_LF || c == tabs_pkg::CH_CR) begin
            hit = 1'b1;
            close_window(verdict);
        end else if (c == tabs_pkg::CH_SLASH && scan.prev_blank) begin
            scan.mode = tabs_pkg::MODE_SLASH;
        end else if (c == tabs_pkg::CH_RBRACE && depth == '0) begin
            hit = 1'b1;
            close_window(verdict);
        end else begin
            if (c == tabs_pkg::CH_RBRACE) begin
                depth = depth - DEPTH_W'(1);
            end else if (c == tabs_pkg::CH_LBRACE) begin
                // saturate at the maximum nesting depth
                if (int'(depth) < int'(tabs_pkg::MAX_BRACE_DEPTH)) depth = depth + DEPTH_W'(1);
            end else if (c == tabs_pkg::CH_LBRACK) begin
                scan.later_bracket = 1'b1;
            end
            if (!is_blank) scan.last_close = (c == tabs_pkg::CH_RBRACK);
            scan.prev_blank = is_blank;
        end
    endtask

    task automatic advance_scan(input logic start, input logic allow, input logic [7:0] c,
                                input logic eof, output logic hit, output logic verdict);
        hit     = 1'b0;
        verdict = 1'b0;
        if (start && !allow) begin
            hit       = 1'b1;
            scan.mode = tabs_pkg::MODE_IDLE;
        end else begin
            if (start) scan.mode = tabs_pkg::MODE_SKIP;
            case (scan.mode)
                tabs_pkg::MODE_SKIP: begin
                    if (!eof && (c == tabs_pkg::CH_SPACE || c == tabs_pkg::CH_TAB)) begin
                        hit = 1'b0;
                    end else if (!eof && c == tabs_pkg::CH_LBRACK) begin
                        scan.mode          = tabs_pkg::MODE_WATCH;
                        scan.later_bracket = 1'b0;
                        scan.last_close    = 1'b0;
                        scan.prev_blank    = 1'b0;
                        depth              = '0;
                    end else begin
                        hit       = 1'b1;
                        scan.mode = tabs_pkg::MODE_IDLE;
                    end
                end
                tabs_pkg::MODE_WATCH: watch_char(c, eof, hit, verdict);
                tabs_pkg::MODE_SLASH: begin
                    if (!eof && (c == tabs_pkg::CH_SLASH || c == tabs_pkg::CH_STAR)) begin
                        hit = 1'b1;
                        close_window(verdict);
                    end else begin
                        // lone slash: resume watching with this character
                        scan.last_close = 1'b0;
                        scan.prev_blank = 1'b0;
                        scan.mode       = tabs_pkg::MODE_WATCH;
                        watch_char(c, eof, hit, verdict);
                    end
                end
                default: hit = 1'b0;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        logic hit;
        logic verdict;
        logic want;
        if (!i_rst_n) begin
            scan          = '0;
            scan.mode     = tabs_pkg::MODE_IDLE;
            depth         = '0;
            verdict_q.delete();
            o_fail_count  = 0;
            o_chars       = 0;
            o_verdicts    = 0;
            o_annotations = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_verdicts++;
                if (i_is_annotation === 1'b1) o_annotations++;
                if (verdict_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result transaction, expected none, actual %0b",
                             $time, i_is_annotation);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_is_annotation !== want) begin
                        o_fail_count++;
                        $display("%0t: is_annotation mismatch, expected %0b, actual %0b",
                                 $time, want, i_is_annotation);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                o_chars++;
                advance_scan(i_start_req, i_allowed, i_ch, i_at_eof, hit, verdict);
                if (hit) verdict_q.push_back(verdict);
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// ----- tb/tb_trailing_annotation_bracket_scanner.sv -----
`timescale 1ns / 1ps
// testbench top for the trailing annotation bracket scanner: drives character
// transactions with bursts and stalls, and gives the verdict from the checker
// depends on tabs_pkg, tabs_scanner_checker and the scanner rtl
module tb_trailing_annotation_bracket_scanner;

    localparam logic [7:0] CH_LETTER_A = 8'h61;
    localparam logic [7:0] CH_LETTER_X = 8'h78;
    localparam int RANDOM_CHARS = 750;
    localparam int LONG_HOLD    = 60;
    localparam int FLOOD_CHARS  = 40;
    localparam int OVERFLOW_OPENS = 258;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_start_req = 1'b0;
    logic       i_allowed   = 1'b0;
    logic [7:0] i_ch        = 8'h00;
    logic       i_at_eof    = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_is_annotation;

    int fail_count;
    int pending;
    int chars_seen;
    int verdicts_seen;
    int annotations_seen;

    int burst_left = 0;
    int chars_counted = 0;
    int long_holds = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    trailing_annotation_bracket_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_req    (i_start_req),
        .i_allowed      (i_allowed),
        .i_ch           (i_ch),
        .i_at_eof       (i_at_eof),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_is_annotation(o_is_annotation)
    );

    tabs_scanner_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_start_req    (i_start_req),
        .i_allowed      (i_allowed),
        .i_ch           (i_ch),
        .i_at_eof       (i_at_eof),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_is_annotation(o_is_annotation),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_chars        (chars_seen),
        .o_verdicts     (verdicts_seen),
        .o_annotations  (annotations_seen)
    );

    // offer one character transaction and return at the edge that takes it
    task automatic send_char(input logic start, input logic allow, input logic [7:0] c,
                             input logic eof);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_valid     <= 1'b0;
            i_start_req <= 1'($urandom);
            i_allowed   <= 1'($urandom);
            i_ch        <= 8'($urandom);
            i_at_eof    <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        i_valid     <= 1'b1;
        i_start_req <= start;
        // allowed only matters on a start
        i_allowed   <= start ? allow : 1'($urandom);
        i_ch        <= c;
        i_at_eof    <= eof;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left > 0) burst_left--;
        chars_counted++;
    endtask

    // stop offering until every outstanding verdict has come back
    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) != 0) ? tabs_pkg::CH_SPACE : tabs_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1:    c = tabs_pkg::CH_RBRACK;
            2:       c = tabs_pkg::CH_LBRACK;
            3:       c = tabs_pkg::CH_LBRACE;
            4:       c = tabs_pkg::CH_RBRACE;
            5:       c = tabs_pkg::CH_SLASH;
            6:       c = tabs_pkg::CH_STAR;
            7:       c = tabs_pkg::CH_SPACE;
            8:       c = tabs_pkg::CH_TAB;
            9:       c = CH_LETTER_A + 8'($urandom_range(0, 25));
            10:      c = 8'($urandom);
            default: c = tabs_pkg::CH_RBRACK;
        endcase
        return c;
    endfunction

    // well-formed attempt: blanks, opener, body, then some way of closing or none
    task automatic gen_attempt();
        logic allow;
        logic first;
        int   n_lead;
        int   n_body;
        allow  = ($urandom_range(0, 15) != 0);
        first  = 1'b1;
        n_lead = $urandom_range(0, 2);
        n_body = $urandom_range(0, 8);
        for (int i = 0; i < n_lead; i++) begin
            send_char(first, allow, blank_char(), 1'b0);
            first = 1'b0;
        end
        send_char(first, allow, tabs_pkg::CH_LBRACK, 1'b0);
        for (int i = 0; i < n_body; i++) send_char(1'b0, 1'b0, body_char(), 1'b0);
        if ($urandom_range(0, 1) != 0) begin
            send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
            if ($urandom_range(0, 2) == 0) send_char(1'b0, 1'b0, blank_char(), 1'b0);
        end
        case ($urandom_range(0, 8))
            0: send_char(1'b0, 1'b0, tabs_pkg::CH_LF, 1'b0);
            1: send_char(1'b0, 1'b0, tabs_pkg::CH_CR, 1'b0);
            2: send_char(1'b0, 1'b0, 8'($urandom), 1'b1);
            3: send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACE, 1'b0);
            4, 5: begin
                send_char(1'b0, 1'b0, blank_char(), 1'b0);
                send_char(1'b0, 1'b0, tabs_pkg::CH_SLASH, 1'b0);
                send_char(1'b0, 1'b0,
                          ($urandom_range(0, 1) != 0) ? tabs_pkg::CH_SLASH : tabs_pkg::CH_STAR,
                          1'b0);
            end
            6: begin
                send_char(1'b0, 1'b0, blank_char(), 1'b0);
                send_char(1'b0, 1'b0, tabs_pkg::CH_SLASH, 1'b0);
                send_char(1'b0, 1'b0, body_char(), 1'b0);
                send_char(1'b0, 1'b0, tabs_pkg::CH_LF, 1'b0);
            end
            7: begin
                send_char(1'b0, 1'b0, blank_char(), 1'b0);
                send_char(1'b0, 1'b0, tabs_pkg::CH_SLASH, 1'b0);
                send_char(1'b0, 1'b0, 8'($urandom), 1'b1);
            end
            default: ; // left open, the next start drops it
        endcase
    endtask

    task automatic gen_noise();
        int n;
        logic start;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            start = ($urandom_range(0, 3) == 0);
            send_char(start, 1'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic gen_broken();
        int n;
        if ($urandom_range(0, 1) != 0) begin
            send_char(1'b1, 1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
            n = $urandom_range(1, 5);
            send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
            for (int i = 0; i < n; i++) send_char(1'b0, 1'b0, 8'($urandom), 1'b0);
        end
    endtask

    // more opens than the depth counter holds, then closes that would only
    // balance if the depth wrapped instead of saturating
    task automatic gen_brace_overflow();
        send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
        repeat (OVERFLOW_OPENS) send_char(1'b0, 1'b0, tabs_pkg::CH_LBRACE, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        repeat (3) send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACE, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_LF, 1'b0);
    endtask

    // back-to-back verdict-producing starts while the output is held off
    task automatic gen_flood();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (FLOOD_CHARS) begin
            if ($urandom_range(0, 1) != 0) send_char(1'b1, 1'b0, 8'($urandom), 1'($urandom));
            else send_char(1'b1, 1'b1, CH_LETTER_X, 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    // receiver: phases of steady, light and heavy stalling, plus long hold-offs
    initial begin : receiver
        int phase_left;
        int pattern;
        phase_left = 0;
        pattern    = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_holds++;
            end else begin
                if (phase_left == 0) begin
                    pattern    = $urandom_range(0, 2);
                    phase_left = $urandom_range(8, 40);
                end
                case (pattern)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
                phase_left--;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        bit overflow_done;
        bit flood_done;
        int pick;
        overflow_done = 1'b0;
        flood_done    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start that is not allowed
        send_char(1'b1, 1'b0, tabs_pkg::CH_LBRACK, 1'b0);
        // blanks, opener, close bracket, line feed
        send_char(1'b1, 1'b1, tabs_pkg::CH_SPACE, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_TAB, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_LF, 1'b0);
        // idle character is ignored
        send_char(1'b0, 1'b1, tabs_pkg::CH_RBRACK, 1'b0);
        // open attempt aborted by a start on something other than a bracket
        send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b1, 1'b1, CH_LETTER_X, 1'b0);
        // end of input right at the start
        send_char(1'b1, 1'b1, 8'hFF, 1'b1);
        // slash after a blank that is not a comment
        send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_SPACE, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_SLASH, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        send_char(1'b0, 1'b0, 8'h00, 1'b1);
        // block comment opener closes the window
        send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_TAB, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_SLASH, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_STAR, 1'b0);
        // nested braces, then a closing brace at depth zero
        send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_LBRACE, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACE, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACE, 1'b0);
        // a later bracket makes it prose
        send_char(1'b1, 1'b1, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_LBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_RBRACK, 1'b0);
        send_char(1'b0, 1'b0, tabs_pkg::CH_CR, 1'b0);
        drain_outputs();

        while (chars_counted < RANDOM_CHARS) begin
            if (!overflow_done && chars_counted >= 150) begin
                gen_brace_overflow();
                overflow_done = 1'b1;
            end
            if (!flood_done && chars_counted >= 450) begin
                gen_flood();
                flood_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) gen_attempt();
            else if (pick < 85) gen_noise();
            else gen_broken();
            if ($urandom_range(0, 39) == 0) drain_outputs();
        end

        drain_outputs();
        repeat (8) @(posedge i_clk);
        $display("run: %0d character transactions, %0d verdicts, %0d annotations",
                 chars_seen, verdicts_seen, annotations_seen);
        $display("run: %0d long output hold-offs, brace overflow and comment closers included",
                 long_holds);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tabs_pkg.sv
sv/tabs_step.sv
sv/tabs_out_reg.sv
sv/trailing_annotation_bracket_scanner.sv
sv/tabs_chk.sv
tb/tabs_scanner_checker.sv
tb/tb_trailing_annotation_bracket_scanner.sv
